[hdl/sfm_pkg.sv]
`default_nettype none

package sfm_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int DIM_W     = 11;
    localparam int PIX_W     = 8;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int FOCUS_W   = 28;

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int N_W   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

    localparam int ABS_W  = 10;
    localparam int MAXG_W = 11;
    localparam int MAG_W  = 21;
    localparam int GSQ_W  = 42;
    localparam int SUM_W  = 42;
    localparam int SQS_W  = 63;
    localparam int PROD_W = 2 * SUM_W;
    localparam int ROOT_W = 50;
    localparam int X_W    = 2 * ROOT_W;
    localparam int FRAC_W = 8;
    localparam int CNT_W  = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_MODE   = 2'd2
    } t_reg_idx;

    localparam logic [MODE_W-1:0] MODE_MAX = 2'd1;
    localparam logic [MODE_W-1:0] MODE_STD = 2'd2;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input int maxv);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (v > DIM_W'(maxv)) begin
            res = DIM_W'(maxv);
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[hdl/sfm_if.sv]
`default_nettype none

interface sfm_pix_if;
    import sfm_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;
    modport source (output valid, output pixel, input ready);
    modport sink (input valid, input pixel, output ready);
endinterface

interface sfm_cfg_if;
    import sfm_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DIM_W-1:0]     data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

interface sfm_res_if;
    import sfm_pkg::*;
    logic               valid;
    logic               ready;
    logic [FOCUS_W-1:0] focus_value;
    logic               mode_valid;
    modport source (output valid, output focus_value, output mode_valid, input ready);
    modport sink (input valid, input focus_value, input mode_valid, output ready);
endinterface

`default_nettype wire

[hdl/sfm_ram.sv]
`default_nettype none

module sfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[hdl/sobel_focus_measure_top.sv]
// Sobel focus measure over a cropped grey region.
// Channels: i_cfg writes region width (index 0), region height (index 1) and
// measure mode (index 2); it is always ready. i_pix carries one 8-bit pixel per
// transaction in raster order. o_res carries one result per region.
// Pixels within a row are taken one per cycle. After the last pixel of every row
// from the second row on, the block stops taking pixels while it sweeps the three
// stored lines held in three line RAMs. After the last pixel of a region of two
// or more rows a second sweep of the same length follows; mode 1 then gives its
// result directly, mode 2 runs the shift-add multiplies, the bit-serial square
// root and the serial divide; other modes give an invalid zero result directly.
// Width and height are sampled at the first pixel of a region and the mode at
// its last pixel.
// Reset clears the state, position, valid and accumulator registers and restores
// width 1024, height 1024, mode 1; the line RAMs need no clearing.
// The result sits in an output register, so pixels of the next region are taken
// while the receiver stalls; a further result waits until that register is free.
`default_nettype none

module sobel_focus_measure_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sfm_cfg_if.sink       i_cfg,
    sfm_pix_if.sink       i_pix,
    sfm_res_if.source     o_res
);
    import sfm_pkg::*;

    typedef enum logic [3:0] {
        ST_PIXEL, ST_SWEEP, ST_DRAIN, ST_LOAD_A, ST_MUL_A, ST_LOAD_B, ST_MUL_B,
        ST_ROOT_LOAD, ST_ROOT, ST_DIV_LOAD, ST_DIV, ST_RESULT
    } t_state;

    typedef logic [1:0] t_slot;

    function automatic logic [PIX_W-1:0] pick(input t_slot s, input logic [PIX_W-1:0] a0,
                                              input logic [PIX_W-1:0] a1,
                                              input logic [PIX_W-1:0] a2);
        logic [PIX_W-1:0] res;
        case (s)
            2'd0: res = a0;
            2'd1: res = a1;
            2'd2: res = a2;
            default: res = a0;
        endcase
        return res;
    endfunction

    function automatic t_slot next_slot(input t_slot s);
        return (s == 2'd2) ? 2'd0 : s + 2'd1;
    endfunction

    t_state r_state;

    logic [DIM_W-1:0]  r_reg_width;
    logic [DIM_W-1:0]  r_reg_height;
    logic [MODE_W-1:0] r_reg_mode;

    logic [DIM_W-1:0]  r_frame_w;
    logic [DIM_W-1:0]  r_frame_h;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    t_slot             r_slot, r_slot_m1, r_slot_m2;
    t_slot             r_sel_t, r_sel_m, r_sel_b;
    t_slot             r_fin_oth, r_fin_mid;
    logic              r_final_pending;
    logic              r_final_sweep;
    logic [MODE_W-1:0] r_mode;
    logic [DIM_W-1:0]  r_sw_col;

    logic [PROD_W-1:0] r_m_acc, r_m_a, r_prod_a;
    logic [SUM_W-1:0]  r_m_b;
    logic [CNT_W-1:0]  r_cnt;
    logic [N_W-1:0]    r_n;
    logic [X_W-1:0]    r_x;
    logic [ROOT_W+1:0] r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [ROOT_W-1:0] r_dvd;
    logic [N_W-1:0]    r_drem;

    logic [FOCUS_W-1:0] r_res_val;
    logic               r_res_mv;
    logic               r_out_vld;
    logic [FOCUS_W-1:0] r_out_focus;
    logic               r_out_mv;

    logic              r_rd_vld;
    logic [DIM_W-1:0]  r_rd_idx;
    logic [PIX_W-1:0]  r_win_l [3];
    logic [PIX_W-1:0]  r_win_c [3];
    logic              r_s1_vld, r_s2_vld, r_s3_vld;
    logic [ABS_W-1:0]  r_ax, r_ay;
    logic [MAG_W-1:0]  r_g;
    logic [MAXG_W-1:0] r_gsum;
    logic [GSQ_W-1:0]  r_gsq;
    logic [MAXG_W-1:0] r_maxg;
    logic [SUM_W-1:0]  r_sum;
    logic [SQS_W-1:0]  r_sqs;

    logic [PIX_W-1:0]  w_rdata [3];
    logic [2:0]        w_we;
    logic              w_pix_acc;
    logic              w_first;
    logic [DIM_W-1:0]  w_w_eff, w_h_eff;
    logic              w_row_end, w_last_row;
    logic              w_out_free;
    logic              w_clr;
    logic              w_pipe_idle;
    logic [2*DIM_W-1:0] w_n_full;

    logic [ROOT_W+3:0] w_rem_t, w_trial, w_rem_d;
    logic              w_sq_ge;
    logic [N_W:0]      w_drem_t, w_drem_d;
    logic              w_dv_ge;
    logic [ROOT_W-1:0] w_dvd_next;

    logic [PIX_W-1:0]  w_d [3];
    logic [PIX_W-1:0]  w_l [3];
    logic [PIX_W-1:0]  w_r [3];
    logic              w_is_first, w_is_last, w_eval;
    logic [ABS_W-1:0]  w_sr, w_sl, w_sb, w_st;
    logic signed [ABS_W+1:0] w_gx, w_gy;
    logic [ABS_W-1:0]  w_agx, w_agy;

    assign w_first   = (r_col == '0) && (r_row == '0);
    assign w_w_eff   = w_first ? clamp_dim(r_reg_width, MAX_WIDTH) : r_frame_w;
    assign w_h_eff   = w_first ? clamp_dim(r_reg_height, MAX_HEIGHT) : r_frame_h;
    assign w_row_end  = (DIM_W'(r_col) + DIM_W'(1)) == w_w_eff;
    assign w_last_row = (DIM_W'(r_row) + DIM_W'(1)) == w_h_eff;

    assign i_pix.ready = (r_state == ST_PIXEL);
    assign w_pix_acc   = i_pix.valid && i_pix.ready;
    assign i_cfg.ready = 1'b1;

    assign w_out_free = !r_out_vld || o_res.ready;
    assign w_clr      = (r_state == ST_RESULT) && w_out_free;
    assign w_pipe_idle = !r_rd_vld && !r_s1_vld && !r_s2_vld && !r_s3_vld;
    assign w_n_full   = r_frame_w * r_frame_h;

    assign o_res.valid       = r_out_vld;
    assign o_res.focus_value = r_out_focus;
    assign o_res.mode_valid  = r_out_mv;

    genvar gi;
    generate
        for (gi = 0; gi < 3; gi++) begin : g_line
            assign w_we[gi] = w_pix_acc && (r_slot == t_slot'(gi));
            sfm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line (
                .i_clk   (i_clk),
                .i_we    (w_we[gi]),
                .i_waddr (r_col),
                .i_wdata (i_pix.pixel),
                .i_raddr (r_sw_col[COL_W-1:0]),
                .o_rdata (w_rdata[gi])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg_width  <= DIM_W'(MAX_WIDTH);
            r_reg_height <= DIM_W'(MAX_HEIGHT);
            r_reg_mode   <= MODE_MAX;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                REG_WIDTH:  r_reg_width  <= i_cfg.data;
                REG_HEIGHT: r_reg_height <= i_cfg.data;
                REG_MODE:   r_reg_mode   <= i_cfg.data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // Square root and divide steps.
    assign w_rem_t  = {r_rem, r_x[X_W-1 -: 2]};
    assign w_trial  = {2'b00, r_root, 2'b01};
    assign w_rem_d  = w_rem_t - w_trial;
    assign w_sq_ge  = w_rem_t >= w_trial;
    assign w_drem_t = {r_drem, r_dvd[ROOT_W-1]};
    assign w_drem_d = w_drem_t - {1'b0, r_n};
    assign w_dv_ge  = w_drem_t >= {1'b0, r_n};
    assign w_dvd_next = {r_dvd[ROOT_W-2:0], w_dv_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_PIXEL;
            r_col           <= '0;
            r_row           <= '0;
            r_slot          <= 2'd0;
            r_slot_m1       <= 2'd2;
            r_slot_m2       <= 2'd1;
            r_final_pending <= 1'b0;
            r_final_sweep   <= 1'b0;
            r_frame_w       <= DIM_W'(MAX_WIDTH);
            r_frame_h       <= DIM_W'(MAX_HEIGHT);
            r_sw_col        <= '0;
            r_cnt           <= '0;
            r_out_vld       <= 1'b0;
        end else begin
            if (w_clr) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && o_res.ready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                ST_PIXEL: begin
                    if (w_pix_acc) begin
                        if (w_first) begin
                            r_frame_w <= w_w_eff;
                            r_frame_h <= w_h_eff;
                        end
                        r_sel_t  <= (r_row == ROW_W'(1) || r_row == '0) ? r_slot : r_slot_m2;
                        r_sel_m  <= (r_row == '0) ? r_slot : r_slot_m1;
                        r_sel_b  <= r_slot;
                        r_sw_col <= '0;
                        if (!w_row_end) begin
                            r_col <= r_col + COL_W'(1);
                        end else begin
                            r_col <= '0;
                            if (w_last_row) begin
                                r_mode    <= r_reg_mode;
                                r_fin_oth <= (r_row == '0) ? r_slot : r_slot_m1;
                                r_fin_mid <= r_slot;
                                r_row     <= '0;
                                r_slot    <= 2'd0;
                                r_slot_m1 <= 2'd2;
                                r_slot_m2 <= 2'd1;
                                r_state   <= ST_SWEEP;
                                if (r_row != '0) begin
                                    r_final_pending <= 1'b1;
                                    r_final_sweep   <= 1'b0;
                                end else begin
                                    r_final_pending <= 1'b0;
                                    r_final_sweep   <= 1'b1;
                                end
                            end else begin
                                r_row     <= r_row + ROW_W'(1);
                                r_slot    <= next_slot(r_slot);
                                r_slot_m1 <= r_slot;
                                r_slot_m2 <= r_slot_m1;
                                r_final_pending <= 1'b0;
                                r_final_sweep   <= 1'b0;
                                if (r_row != '0) begin
                                    r_state <= ST_SWEEP;
                                end
                            end
                        end
                    end
                end
                ST_SWEEP: begin
                    r_sw_col <= r_sw_col + DIM_W'(1);
                    if (r_sw_col == r_frame_w) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (w_pipe_idle) begin
                        if (r_final_sweep) begin
                            case (r_mode)
                                MODE_MAX: begin
                                    r_res_val <= FOCUS_W'({r_maxg, {FRAC_W{1'b0}}});
                                    r_res_mv  <= 1'b1;
                                    r_state   <= ST_RESULT;
                                end
                                MODE_STD: begin
                                    r_state <= ST_LOAD_A;
                                end
                                default: begin
                                    r_res_val <= '0;
                                    r_res_mv  <= 1'b0;
                                    r_state   <= ST_RESULT;
                                end
                            endcase
                        end else if (r_final_pending) begin
                            r_sel_t         <= r_fin_oth;
                            r_sel_m         <= r_fin_mid;
                            r_sel_b         <= r_fin_oth;
                            r_final_pending <= 1'b0;
                            r_final_sweep   <= 1'b1;
                            r_sw_col        <= '0;
                            r_state         <= ST_SWEEP;
                        end else begin
                            r_state <= ST_PIXEL;
                        end
                    end
                end
                ST_LOAD_A: begin
                    r_n     <= w_n_full[N_W-1:0];
                    r_m_acc <= '0;
                    r_m_a   <= PROD_W'(r_sqs);
                    r_m_b   <= SUM_W'(w_n_full[N_W-1:0]);
                    r_cnt   <= '0;
                    r_state <= ST_MUL_A;
                end
                ST_MUL_A, ST_MUL_B: begin
                    r_m_acc <= r_m_acc + (r_m_b[0] ? r_m_a : '0);
                    r_m_a   <= {r_m_a[PROD_W-2:0], 1'b0};
                    r_m_b   <= {1'b0, r_m_b[SUM_W-1:1]};
                    r_cnt   <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(SUM_W - 1)) begin
                        r_state <= (r_state == ST_MUL_A) ? ST_LOAD_B : ST_ROOT_LOAD;
                    end
                end
                ST_LOAD_B: begin
                    r_prod_a <= r_m_acc;
                    r_m_acc  <= '0;
                    r_m_a    <= PROD_W'(r_sum);
                    r_m_b    <= r_sum;
                    r_cnt    <= '0;
                    r_state  <= ST_MUL_B;
                end
                ST_ROOT_LOAD: begin
                    if (r_m_acc > r_prod_a) begin
                        r_res_val <= '0;
                        r_res_mv  <= 1'b1;
                        r_state   <= ST_RESULT;
                    end else begin
                        r_x     <= X_W'({r_prod_a - r_m_acc, 16'h0000});
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_cnt   <= '0;
                        r_state <= ST_ROOT;
                    end
                end
                ST_ROOT: begin
                    r_x    <= {r_x[X_W-3:0], 2'b00};
                    r_rem  <= w_sq_ge ? w_rem_d[ROOT_W+1:0] : w_rem_t[ROOT_W+1:0];
                    r_root <= {r_root[ROOT_W-2:0], w_sq_ge};
                    r_cnt  <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(ROOT_W - 1)) begin
                        r_state <= ST_DIV_LOAD;
                    end
                end
                ST_DIV_LOAD: begin
                    r_dvd   <= r_root;
                    r_drem  <= '0;
                    r_cnt   <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_dvd  <= w_dvd_next;
                    r_drem <= w_dv_ge ? w_drem_d[N_W-1:0] : w_drem_t[N_W-1:0];
                    r_cnt  <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(ROOT_W - 1)) begin
                        r_res_val <= (|w_dvd_next[ROOT_W-1:FOCUS_W]) ? {FOCUS_W{1'b1}}
                                                                    : w_dvd_next[FOCUS_W-1:0];
                        r_res_mv  <= 1'b1;
                        r_state   <= ST_RESULT;
                    end
                end
                ST_RESULT: begin
                    if (w_out_free) begin
                        r_out_focus <= r_res_val;
                        r_out_mv    <= r_res_mv;
                        r_state     <= ST_PIXEL;
                    end
                end
                default: r_state <= ST_PIXEL;
            endcase
        end
    end

    // Gradient window: tick k evaluates column k-1 with reflected borders.
    assign w_eval     = r_rd_vld && (r_rd_idx != '0);
    assign w_is_first = r_rd_idx == DIM_W'(1);
    assign w_is_last  = r_rd_idx == r_frame_w;

    always_comb begin
        w_d[0] = pick(r_sel_t, w_rdata[0], w_rdata[1], w_rdata[2]);
        w_d[1] = pick(r_sel_m, w_rdata[0], w_rdata[1], w_rdata[2]);
        w_d[2] = pick(r_sel_b, w_rdata[0], w_rdata[1], w_rdata[2]);
        for (int j = 0; j < 3; j++) begin
            w_l[j] = w_is_first ? (w_is_last ? r_win_c[j] : w_d[j]) : r_win_l[j];
            w_r[j] = w_is_last ? (w_is_first ? r_win_c[j] : r_win_l[j]) : w_d[j];
        end
        w_sr = ABS_W'(w_r[0]) + ABS_W'({w_r[1], 1'b0}) + ABS_W'(w_r[2]);
        w_sl = ABS_W'(w_l[0]) + ABS_W'({w_l[1], 1'b0}) + ABS_W'(w_l[2]);
        w_sb = ABS_W'(w_l[2]) + ABS_W'({r_win_c[2], 1'b0}) + ABS_W'(w_r[2]);
        w_st = ABS_W'(w_l[0]) + ABS_W'({r_win_c[0], 1'b0}) + ABS_W'(w_r[0]);
        w_gx = $signed({2'b00, w_sr}) - $signed({2'b00, w_sl});
        w_gy = $signed({2'b00, w_sb}) - $signed({2'b00, w_st});
        w_agx = (w_gx < 0) ? ABS_W'(-w_gx) : ABS_W'(w_gx);
        w_agy = (w_gy < 0) ? ABS_W'(-w_gy) : ABS_W'(w_gy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_maxg   <= '0;
            r_sum    <= '0;
            r_sqs    <= '0;
        end else begin
            r_rd_vld <= (r_state == ST_SWEEP);
            r_rd_idx <= r_sw_col;
            if (r_rd_vld) begin
                for (int j = 0; j < 3; j++) begin
                    r_win_l[j] <= r_win_c[j];
                    r_win_c[j] <= w_d[j];
                end
            end
            r_s1_vld <= w_eval;
            r_ax     <= w_agx;
            r_ay     <= w_agy;
            r_s2_vld <= r_s1_vld;
            r_g      <= MAG_W'(r_ax) * MAG_W'(r_ax) + MAG_W'(r_ay) * MAG_W'(r_ay);
            r_gsum   <= MAXG_W'(r_ax) + MAXG_W'(r_ay);
            r_s3_vld <= r_s2_vld;
            r_gsq    <= GSQ_W'(r_g) * GSQ_W'(r_g);
            if (w_clr) begin
                r_maxg <= '0;
                r_sum  <= '0;
                r_sqs  <= '0;
            end else begin
                if (r_s2_vld) begin
                    r_sum <= r_sum + SUM_W'(r_g);
                    if (r_gsum > r_maxg) begin
                        r_maxg <= r_gsum;
                    end
                end
                if (r_s3_vld) begin
                    r_sqs <= r_sqs + SQS_W'(r_gsq);
                end
            end
        end
    end

endmodule

`default_nettype wire

[hdl/sfm_checker.sv]
`default_nettype none

module sfm_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_res_valid,
    input logic                        i_res_ready,
    input logic [sfm_pkg::FOCUS_W-1:0] i_res_focus,
    input logic                        i_res_mode_valid
);
    import sfm_pkg::*;

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("Result withdrawn before its transaction completed.");

    a_hold_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> $stable(i_res_focus) && $stable(i_res_mode_valid))
        else $error("Result payload changed while stalled.");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_mode_valid |-> i_res_focus == '0)
        else $error("Invalid mode result carries a non-zero value.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("Result offered straight after reset.");

endmodule

bind sobel_focus_measure_top sfm_checker u_sfm_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_res_valid      (o_res.valid),
    .i_res_ready      (o_res.ready),
    .i_res_focus      (o_res.focus_value),
    .i_res_mode_valid (o_res.mode_valid)
);

`default_nettype wire
